/* hdl/vhc_pkg.sv */
// Package: types, constants and codes shared by the Huffman codebook block.
`timescale 1ns / 1ps
package vhc_pkg;
  localparam int unsigned MAX_ENTRIES_DEF  = 1024;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_BEGIN = 2'd2,
    REQ_BIT   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MORE    = 3'd1,
    ST_SYMBOL  = 3'd2,
    ST_INVALID = 3'd3,
    ST_SETUP   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_DONE,
    S_BIT_RD,
    S_BIT_EV,
    S_PL_RD,
    S_PL_EV,
    S_PL_NEW,
    S_PL_BK,
    S_UP_RD,
    S_UP_EV
  } fsm_t;
endpackage

/* hdl/vhc_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module vhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/vorbis_huffman_codebook.sv */
// Top level: Vorbis codebook prefix-tree builder and bit-serial walker.
`timescale 1ns / 1ps
// One word is in flight at a time: busy is high from the accepting edge through
// the out_valid cycle, and after reset while the root node is written. Begin
// words, zero-length loads and words answered with an error or no tree go
// straight to the result; a clear first writes the root node, a bit first
// does one node memory read. A placing load reads and evaluates each level it
// descends, writes each node it creates, steps past each child that is a leaf
// or full subtree, and on the way back up rereads and rewrites each level to
// refresh the full flags; on a dead end it backs out level by level and
// rereads the node whose other child is tried. All node state sits in one
// single-port RAM, one row per node holding both children and the full flag
// of each. Results appear for one cycle with out_valid and cannot be stalled.
module vorbis_huffman_codebook #(
  parameter int unsigned MAX_ENTRIES  = vhc_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned MAX_CODE_LEN = vhc_pkg::MAX_CODE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_code_length,
  input  logic       in_bit_value,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [9:0] out_entry_index
);
  import vhc_pkg::*;

  localparam int unsigned POOL = 2 * MAX_ENTRIES;
  localparam int unsigned NW   = $clog2(POOL);
  localparam int unsigned EW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW   = $clog2(MAX_ENTRIES);
  localparam int unsigned SW   = NW + 1;          // slot: leaf flag + payload
  localparam int unsigned RW   = 2 * SW + 2;
  localparam int unsigned PW   = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam logic [NW:0]   POOL_N  = POOL[NW:0];
  localparam logic [EW-1:0] ENT_MAX = MAX_ENTRIES[EW-1:0];
  localparam logic [5:0]    LEN_MAX = MAX_CODE_LEN[5:0];

  // slot encoding: all zero = empty, msb set = leaf with entry, else node
  fsm_t state_r, state_nxt;
  logic [5:0]    len_r, len_nxt;
  logic          bit_r, bit_nxt;
  logic [NW:0]   ncount_r, ncount_nxt;
  logic [EW-1:0] loaded_r, loaded_nxt;
  logic [EW-1:0] used_r, used_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic [NW-1:0] walk_r, walk_nxt;
  logic          err_r, err_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [IW-1:0] ent_r, ent_nxt;
  logic [PW-1:0] depth_r, depth_nxt;
  logic          cf_r, cf_nxt;
  logic [NW-1:0] child_r, child_nxt;

  logic [NW-1:0] path_node_r [MAX_CODE_LEN];
  logic          path_b_r    [MAX_CODE_LEN];
  logic          path_we;
  logic [PW-1:0] path_idx;
  logic [NW-1:0] path_node_wd;
  logic          path_b_wd;

  logic          we;
  logic [NW-1:0] addr;
  logic [RW-1:0] wdata, rdata;
  logic [SW-1:0] rz, ro;
  logic          rzf, rof;

  vhc_ram #(.WIDTH(RW), .DEPTH(POOL)) u_nodes (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign rz  = rdata[RW-1:SW+2];
  assign rzf = rdata[SW+1];
  assign ro  = rdata[SW:1];
  assign rof = rdata[0];

  function automatic logic slot_open(logic [SW-1:0] s, logic full);
    return (s == '0) || (!s[SW-1] && !full);
  endfunction

  logic [NW-1:0] cur_node, par_node;
  logic          cur_b, par_b;
  logic [PW-1:0] par_idx;
  logic [5:0]    lvl1;
  logic [SW-1:0] sel, leafv, nz, no;
  logic          sel_f, nzf, nof, nfull, lvl_done;
  logic [IW-1:0] idx;

  assign cur_node = path_node_r[depth_r];
  assign cur_b    = path_b_r[depth_r];
  assign par_idx  = depth_r - 1'b1;
  assign par_node = path_node_r[par_idx];
  assign par_b    = path_b_r[par_idx];
  assign lvl1     = 6'(depth_r) + 6'd1;
  assign idx      = loaded_r[IW-1:0];
  assign leafv    = {1'b1, {(NW-IW){1'b0}}, idx};

  always_comb begin
    state_nxt = state_r; len_nxt = len_r; bit_nxt = bit_r;
    ncount_nxt = ncount_r; loaded_nxt = loaded_r; used_nxt = used_r;
    last_nxt = last_r; walk_nxt = walk_r; err_nxt = err_r;
    st_nxt = st_r; ent_nxt = ent_r;
    depth_nxt = depth_r; cf_nxt = cf_r; child_nxt = child_r;
    path_we = 1'b0; path_idx = depth_r; path_node_wd = cur_node; path_b_wd = 1'b0;
    we = 1'b0; addr = cur_node; wdata = rdata;
    sel = '0; sel_f = 1'b0; nz = rz; nzf = rzf; no = ro; nof = rof;
    nfull = 1'b0; lvl_done = 1'b0;
    unique case (state_r)
      S_INIT: begin
        we = 1'b1; addr = '0; wdata = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          len_nxt = in_code_length; bit_nxt = in_bit_value;
          st_nxt = ST_OK; ent_nxt = '0; state_nxt = S_DONE;
          unique case (req_t'(in_req_type))
            REQ_CLEAR: begin
              ncount_nxt = {{NW{1'b0}}, 1'b1}; loaded_nxt = '0; used_nxt = '0;
              last_nxt = '0; walk_nxt = '0; err_nxt = 1'b0;
              state_nxt = S_CLR;
            end
            REQ_LOAD: begin
              if (err_r) begin
                st_nxt = ST_SETUP;
              end else if (loaded_r >= ENT_MAX || in_code_length > LEN_MAX) begin
                err_nxt = 1'b1; st_nxt = ST_SETUP;
              end else if (in_code_length == '0) begin
                loaded_nxt = loaded_r + 1'b1;
              end else begin
                depth_nxt = '0;
                path_we = 1'b1; path_idx = '0; path_node_wd = '0; path_b_wd = 1'b0;
                state_nxt = S_PL_RD;
              end
            end
            REQ_BEGIN: begin
              if (err_r) begin
                st_nxt = ST_SETUP;
              end else begin
                walk_nxt = '0;
                if (used_r == '0) begin
                  st_nxt = ST_INVALID;
                end else if (used_r == {{(EW-1){1'b0}}, 1'b1}) begin
                  st_nxt = ST_SYMBOL; ent_nxt = last_r;
                end else begin
                  st_nxt = ST_MORE;
                end
              end
            end
            REQ_BIT: begin
              if (err_r) begin
                st_nxt = ST_SETUP;
              end else if (used_r == '0) begin
                walk_nxt = '0; st_nxt = ST_INVALID;
              end else begin
                state_nxt = S_BIT_RD;
              end
            end
          endcase
        end
      end
      S_CLR: begin
        we = 1'b1; addr = '0; wdata = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      S_BIT_RD: begin
        addr = walk_r;
        state_nxt = S_BIT_EV;
      end
      S_BIT_EV: begin
        addr = walk_r;
        sel = bit_r ? ro : rz;
        if (sel == '0) begin
          walk_nxt = '0; st_nxt = ST_INVALID;
        end else if (sel[SW-1]) begin
          walk_nxt = '0; st_nxt = ST_SYMBOL; ent_nxt = sel[IW-1:0];
        end else begin
          walk_nxt = sel[NW-1:0]; st_nxt = ST_MORE;
        end
        state_nxt = S_DONE;
      end
      S_PL_RD: begin
        state_nxt = S_PL_EV;
      end
      S_PL_EV: begin
        if (lvl1 == len_r) begin
          if (rz == '0) nz = leafv;
          else if (ro == '0) no = leafv;
          if (rz == '0 || ro == '0) begin
            we = 1'b1;
            wdata = {nz, nzf, no, nof};
            nfull = !slot_open(nz, nzf) && !slot_open(no, nof);
            lvl_done = 1'b1;
          end else begin
            state_nxt = S_PL_BK;
          end
        end else begin
          sel = cur_b ? ro : rz;
          sel_f = cur_b ? rof : rzf;
          if (sel[SW-1] || (sel != '0 && sel_f)) begin
            // skip a leaf or a full subtree
            if (!cur_b) begin
              path_we = 1'b1; path_b_wd = 1'b1;
            end else begin
              state_nxt = S_PL_BK;
            end
          end else if (sel == '0) begin
            if (ncount_r >= POOL_N) begin
              state_nxt = S_PL_BK;
            end else begin
              if (cur_b) begin
                no = {1'b0, ncount_r[NW-1:0]}; nof = 1'b0;
              end else begin
                nz = {1'b0, ncount_r[NW-1:0]}; nzf = 1'b0;
              end
              we = 1'b1;
              wdata = {nz, nzf, no, nof};
              child_nxt = ncount_r[NW-1:0];
              ncount_nxt = ncount_r + 1'b1;
              state_nxt = S_PL_NEW;
            end
          end else begin
            path_we = 1'b1; path_idx = depth_r + 1'b1;
            path_node_wd = sel[NW-1:0]; path_b_wd = 1'b0;
            depth_nxt = depth_r + 1'b1;
            state_nxt = S_PL_RD;
          end
        end
      end
      S_PL_NEW: begin
        we = 1'b1; addr = child_r; wdata = '0;
        path_we = 1'b1; path_idx = depth_r + 1'b1;
        path_node_wd = child_r; path_b_wd = 1'b0;
        depth_nxt = depth_r + 1'b1;
        state_nxt = S_PL_RD;
      end
      S_PL_BK: begin
        if (depth_r == '0) begin
          err_nxt = 1'b1; loaded_nxt = loaded_r + 1'b1;
          st_nxt = ST_SETUP; state_nxt = S_DONE;
        end else begin
          depth_nxt = par_idx;
          if (!par_b) begin
            path_we = 1'b1; path_idx = par_idx; path_node_wd = par_node; path_b_wd = 1'b1;
            state_nxt = S_PL_RD;
          end
        end
      end
      S_UP_RD: begin
        state_nxt = S_UP_EV;
      end
      S_UP_EV: begin
        if (cur_b) nof = cf_r;
        else nzf = cf_r;
        we = 1'b1;
        wdata = {nz, nzf, no, nof};
        nfull = !slot_open(nz, nzf) && !slot_open(no, nof);
        lvl_done = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (lvl_done) begin
      if (depth_r == '0) begin
        used_nxt = used_r + 1'b1; last_nxt = idx;
        loaded_nxt = loaded_r + 1'b1;
        st_nxt = ST_OK; state_nxt = S_DONE;
      end else begin
        cf_nxt = nfull; depth_nxt = par_idx;
        state_nxt = S_UP_RD;
      end
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_status = st_r;
  assign out_entry_index = 10'(ent_r);

  always_ff @(posedge clk) begin
    if (rst_n && path_we) begin
      path_node_r[path_idx] <= path_node_wd;
      path_b_r[path_idx]    <= path_b_wd;
    end
    if (!rst_n) begin
      state_r <= S_INIT; len_r <= '0; bit_r <= 1'b0;
      ncount_r <= {{NW{1'b0}}, 1'b1}; loaded_r <= '0; used_r <= '0;
      last_r <= '0; walk_r <= '0; err_r <= 1'b0; st_r <= ST_OK; ent_r <= '0;
      depth_r <= '0; cf_r <= 1'b0; child_r <= '0;
    end else begin
      state_r <= state_nxt; len_r <= len_nxt; bit_r <= bit_nxt;
      ncount_r <= ncount_nxt; loaded_r <= loaded_nxt;
      used_r <= used_nxt; last_r <= last_nxt; walk_r <= walk_nxt;
      err_r <= err_nxt; st_r <= st_nxt; ent_r <= ent_nxt;
      depth_r <= depth_nxt; cf_r <= cf_nxt; child_r <= child_nxt;
    end
  end
endmodule
